// File: src/iir3_pkg.sv
// Shared types and constants for the third-order multichannel IIR low-pass filter.
// Used by the top level, iir3_mac and the testbench; depends on nothing.
package iir3_pkg;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 32;
  localparam int CH_W     = 3;
  localparam int TAPS     = 3;
  localparam int NUM_REGS = 7;
  localparam int REG_IDX_W = 3;
  localparam int STEP_W   = 3;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + 4;

  localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_A3 = 3'd6;

  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] filtered;
  } out_item_t;

  // x1, x2, x3, y1, y2, y3 of one channel
  typedef logic [2*TAPS-1:0][SAMPLE_W-1:0] hist_row_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic sub;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_MAC,
    S_DONE
  } state_e;

endpackage

// File: src/multichannel_iir_lowpass_order3.sv
// Top level of the multichannel third-order direct-form-I IIR low-pass filter.
// Depends on iir3_pkg, iir3_ram and iir3_mac.
//
//   channel  | direction | handshake                | payload
//   in       | input     | in_valid_i / in_stall_o  | in_item_i  (channel, sample)
//   out      | output    | out_valid_o / out_stall_i| out_item_o (out_channel, filtered)
//   cfg      | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// An item waits in the input register, then passes through the core: one history RAM read,
// seven products through the one 32x32 multiplier, then round, saturate and write back.
// A new item leaves the input register only while the core is idle or writing back the last one.
// After reset coefficients are zero and per-channel valid bits make histories read zero.
// A stalled output holds the core in write-back; the input register still takes one item.
module multichannel_iir_lowpass_order3 #(
  parameter int CHANNELS       = 6,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  iir3_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output iir3_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [iir3_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [iir3_pkg::COEF_W-1:0]           cfg_data_i
);

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_W = $bits(iir3_pkg::hist_row_t);
  localparam int SW    = iir3_pkg::SAMPLE_W;

  logic signed [iir3_pkg::COEF_W-1:0] coef_q [iir3_pkg::NUM_REGS];

  logic                 a_valid_q;
  iir3_pkg::in_item_t   a_q;

  iir3_pkg::state_e     state_q, state_d;
  logic [iir3_pkg::STEP_W-1:0] step_q, step_d;
  logic [iir3_pkg::CH_W-1:0]   ch_q;
  logic [AW-1:0]        addr_q;
  logic                 oor_q;
  logic signed [SW-1:0] opnd_q [iir3_pkg::NUM_REGS];

  logic [CHANNELS-1:0]  ent_valid_q;
  logic                 fwd_valid_q;
  logic [AW-1:0]        fwd_addr_q;
  iir3_pkg::hist_row_t  fwd_row_q;

  logic                 out_valid_q;
  iir3_pkg::out_item_t  out_item_q;

  logic                 a_oor;
  logic [AW-1:0]        a_addr;
  logic                 done_fire;
  logic                 take;
  logic                 ram_we;
  iir3_pkg::hist_row_t  new_row;
  iir3_pkg::hist_row_t  rd_row;
  iir3_pkg::hist_row_t  row_src;
  logic [ROW_W-1:0]     ram_rdata;
  iir3_pkg::mac_ctrl_t  mac_ctrl;
  logic signed [iir3_pkg::COEF_W-1:0] mul_coef;
  logic signed [SW-1:0] mul_opnd;
  logic signed [SW-1:0] y;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < iir3_pkg::NUM_REGS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i && (int'(cfg_idx_i) < iir3_pkg::NUM_REGS)) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // input register
  assign in_stall_o = a_valid_q;
  assign a_oor      = int'(a_q.channel) >= CHANNELS;
  assign a_addr     = a_oor ? '0 : AW'(a_q.channel);
  assign done_fire  = !out_valid_q || !out_stall_i;
  assign take       = a_valid_q &&
                      ((state_q == iir3_pkg::S_IDLE) ||
                       ((state_q == iir3_pkg::S_DONE) && done_fire));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      a_valid_q <= 1'b1;
    end else if (take) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      a_q <= in_item_i;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    mac_ctrl = '0;
    ram_we   = 1'b0;
    case (state_q)
      iir3_pkg::S_IDLE: begin
        if (take) begin
          state_d = iir3_pkg::S_LOAD;
        end
      end
      iir3_pkg::S_LOAD: begin
        mac_ctrl.clear = 1'b1;
        step_d  = '0;
        state_d = iir3_pkg::S_MAC;
      end
      iir3_pkg::S_MAC: begin
        mac_ctrl.mul_en = step_q != iir3_pkg::STEP_LAST;
        mac_ctrl.acc_en = step_q != '0;
        mac_ctrl.sub    = step_q > iir3_pkg::REG_A1;
        step_d          = step_q + 1'b1;
        if (step_q == iir3_pkg::STEP_LAST) begin
          state_d = iir3_pkg::S_DONE;
        end
      end
      iir3_pkg::S_DONE: begin
        if (done_fire) begin
          ram_we  = !oor_q;
          state_d = take ? iir3_pkg::S_LOAD : iir3_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = iir3_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iir3_pkg::S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // history row: forward the last write, zero for a never-written channel
  assign rd_row  = ram_rdata;
  assign row_src = (fwd_valid_q && (fwd_addr_q == addr_q)) ? fwd_row_q :
                   (ent_valid_q[addr_q] ? rd_row : '0);

  always_ff @(posedge clk_i) begin
    if (take) begin
      ch_q      <= a_q.channel;
      addr_q    <= a_addr;
      oor_q     <= a_oor;
      opnd_q[0] <= a_q.sample;
    end
    if (state_q == iir3_pkg::S_LOAD) begin
      for (int i = 0; i < 2 * iir3_pkg::TAPS; i++) begin
        opnd_q[i+1] <= row_src[i];
      end
    end
  end

  assign mul_coef = (step_q != iir3_pkg::STEP_LAST) ? coef_q[step_q] : '0;
  assign mul_opnd = (step_q != iir3_pkg::STEP_LAST) ? opnd_q[step_q] : '0;

  iir3_mac #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .coef_i  (mul_coef),
    .opnd_i  (mul_opnd),
    .result_o(y)
  );

  assign new_row[0] = opnd_q[0];
  assign new_row[1] = opnd_q[1];
  assign new_row[2] = opnd_q[2];
  assign new_row[3] = y;
  assign new_row[4] = opnd_q[4];
  assign new_row[5] = opnd_q[5];

  iir3_ram #(
    .WIDTH(ROW_W),
    .DEPTH(CHANNELS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(new_row),
    .re_i   (take),
    .raddr_i(a_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      fwd_valid_q <= 1'b0;
    end else if (ram_we) begin
      ent_valid_q[addr_q] <= 1'b1;
      fwd_valid_q         <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_addr_q <= addr_q;
      fwd_row_q  <= new_row;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == iir3_pkg::S_DONE) && done_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == iir3_pkg::S_DONE) && done_fire) begin
      out_item_q.out_channel <= ch_q;
      out_item_q.filtered    <= oor_q ? '0 : y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_take_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (state_q == iir3_pkg::S_IDLE || state_q == iir3_pkg::S_DONE))
    else $error("item taken while core busy");

  a_load_then_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iir3_pkg::S_LOAD |=> state_q == iir3_pkg::S_MAC)
    else $error("load not followed by mac");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == iir3_pkg::S_DONE)
    else $error("result without write-back");

  a_no_oor_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !oor_q && (int'(ch_q) < CHANNELS))
    else $error("history write for invalid channel");
`endif

endmodule

// File: src/iir3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module iir3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/iir3_mac.sv
// Shared multiply-accumulate unit: one registered 32x32 product per cycle while multiplication
// is enabled, exact accumulator, round to nearest and saturation. Depends on iir3_pkg.
module iir3_mac #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                clk_i,
  input  iir3_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [iir3_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [iir3_pkg::SAMPLE_W-1:0] opnd_i,
  output logic signed [iir3_pkg::SAMPLE_W-1:0] result_o
);

  localparam int AW = iir3_pkg::ACC_W;
  localparam int SW = iir3_pkg::SAMPLE_W;

  logic signed [iir3_pkg::PROD_W-1:0] prod_q;
  logic signed [AW-1:0]               acc_q;
  logic signed [AW-1:0]               prod_ext;
  logic signed [AW-1:0]               rnd;
  logic signed [AW-1:0]               shr;
  logic                               fits;

  assign prod_ext = AW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= coef_i * opnd_i;
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= ctrl_i.sub ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  // ties go toward plus infinity
  always_comb begin
    rnd  = acc_q + (AW'(1) <<< (COEF_FRAC_BITS - 1));
    shr  = rnd >>> COEF_FRAC_BITS;
    fits = (&shr[AW-1:SW-1]) | ~(|shr[AW-1:SW-1]);
    if (fits) begin
      result_o = shr[SW-1:0];
    end else if (shr[AW-1]) begin
      result_o = {1'b1, {(SW-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

// File: tb/sv/multichannel_iir_lowpass_order3_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multichannel_iir_lowpass_order3: exact-sum filter predictor,
// queued driver and monitor with random idling, coefficient sets from tiny to extreme.
// Depends on iir3_pkg and the filter RTL.
module multichannel_iir_lowpass_order3_tb;

  localparam int CHANNELS       = 6;
  localparam int COEF_FRAC_BITS = 28;
  localparam int SUM_W          = 72;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int PHASES         = 6;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam logic [iir3_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [SUM_W-1:0] HALF_LSB = 1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI   = 2147483647;
  localparam logic signed [SUM_W-1:0] SAT_LO   = $signed(32'h8000_0000);

  typedef enum int {
    COEFS_LOWPASS,
    COEFS_SMALL,
    COEFS_FULL,
    COEFS_EDGE
  } coef_set_e;

  logic                                clk_i;
  logic                                rst_ni      = 1'b0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_stall_o;
  iir3_pkg::in_item_t                  in_item_i   = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  iir3_pkg::out_item_t                 out_item_o;
  logic                                cfg_we_i    = 1'b0;
  logic [iir3_pkg::REG_IDX_W-1:0]      cfg_idx_i   = '0;
  logic [iir3_pkg::COEF_W-1:0]         cfg_data_i  = '0;

  multichannel_iir_lowpass_order3 #(
    .CHANNELS      (CHANNELS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // filter state as the block should hold it
  logic signed [iir3_pkg::COEF_W-1:0]   coef_q [iir3_pkg::NUM_REGS];
  logic signed [iir3_pkg::SAMPLE_W-1:0] x_hist [CHANNELS][iir3_pkg::TAPS];
  logic signed [iir3_pkg::SAMPLE_W-1:0] y_hist [CHANNELS][iir3_pkg::TAPS];

  iir3_pkg::in_item_t  pending_samples[$];
  iir3_pkg::out_item_t expected_filtered[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req      = 1'b0;
  bit  item_taken    = 1'b0;
  int  cycle_count   = 0;
  int  mismatch_count     = 0;
  int  accepted_count     = 0;
  int  checked_count      = 0;
  int  saturated_count    = 0;
  int  idle_channel_count = 0;
  int  setting_count      = 0;

  function automatic iir3_pkg::out_item_t filter_sample(iir3_pkg::in_item_t it);
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] y;
    iir3_pkg::out_item_t r;
    int ch;
    ch = it.channel;
    r.out_channel = it.channel;
    r.filtered = '0;
    if (ch >= CHANNELS) begin
      idle_channel_count++;
      return r;
    end
    acc = coef_q[iir3_pkg::REG_B0] * $signed(it.sample)
        + coef_q[iir3_pkg::REG_B1] * x_hist[ch][0]
        + coef_q[iir3_pkg::REG_B2] * x_hist[ch][1]
        + coef_q[iir3_pkg::REG_B3] * x_hist[ch][2]
        - coef_q[iir3_pkg::REG_A1] * y_hist[ch][0]
        - coef_q[iir3_pkg::REG_A2] * y_hist[ch][1]
        - coef_q[iir3_pkg::REG_A3] * y_hist[ch][2];
    y = (acc + HALF_LSB) >>> COEF_FRAC_BITS;
    if (y > SAT_HI) begin
      y = SAT_HI;
      saturated_count++;
    end else if (y < SAT_LO) begin
      y = SAT_LO;
      saturated_count++;
    end
    x_hist[ch][2] = x_hist[ch][1];
    x_hist[ch][1] = x_hist[ch][0];
    x_hist[ch][0] = it.sample;
    y_hist[ch][2] = y_hist[ch][1];
    y_hist[ch][1] = y_hist[ch][0];
    y_hist[ch][0] = y[iir3_pkg::SAMPLE_W-1:0];
    r.filtered = y[iir3_pkg::SAMPLE_W-1:0];
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (!in_valid_i || item_taken) begin
      item_taken = 1'b0;
      if (rst_ni && pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_samples[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    iir3_pkg::out_item_t want;
    if (rst_ni) begin
      cycle_count++;
      if (in_valid_i && !in_stall_o) begin
        expected_filtered.push_back(filter_sample(in_item_i));
        void'(pending_samples.pop_front());
        item_taken = 1'b1;
        accepted_count++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_filtered.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item: expected none, actual ch %0d filtered %0d",
                   $time, out_item_o.out_channel, $signed(out_item_o.filtered));
        end else begin
          want = expected_filtered.pop_front();
          checked_count++;
          if (out_item_o.out_channel !== want.out_channel) begin
            mismatch_count++;
            $display("%0t: out_channel expected %0d actual %0d",
                     $time, want.out_channel, out_item_o.out_channel);
          end
          if (out_item_o.filtered !== want.filtered) begin
            mismatch_count++;
            $display("%0t: filtered (ch %0d) expected %0d actual %0d", $time,
                     want.out_channel, $signed(want.filtered), $signed(out_item_o.filtered));
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  task automatic send(input logic [iir3_pkg::CH_W-1:0] ch,
                      input logic [iir3_pkg::SAMPLE_W-1:0] smp);
    iir3_pkg::in_item_t it;
    it.channel = ch;
    it.sample  = smp;
    pending_samples.push_back(it);
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || expected_filtered.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [iir3_pkg::REG_IDX_W-1:0] idx,
                           input logic [iir3_pkg::COEF_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx < iir3_pkg::NUM_REGS) coef_q[idx] = val;
  endtask

  function automatic logic [iir3_pkg::COEF_W-1:0] pick_coef(coef_set_e kind);
    case (kind)
      COEFS_SMALL: return int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      COEFS_FULL:  return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h1000_0000;
          3:       return 32'hF000_0000;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic load_coefs(coef_set_e kind);
    logic [iir3_pkg::REG_IDX_W-1:0] idx;
    if (kind == COEFS_LOWPASS) begin
      // third-order Butterworth taps for a cutoff at a tenth of Nyquist, but a2 is 1.0 too high
      write_reg(iir3_pkg::REG_B0, 32'sd777986);
      write_reg(iir3_pkg::REG_B1, 32'sd2333962);
      write_reg(iir3_pkg::REG_B2, 32'sd2333962);
      write_reg(iir3_pkg::REG_B3, 32'sd777986);
      write_reg(iir3_pkg::REG_A1, -32'sd637291206);
      write_reg(iir3_pkg::REG_A2, 32'sd786342908);
      write_reg(iir3_pkg::REG_A3, -32'sd142827892);
    end else begin
      for (int r = iir3_pkg::REG_B0; r <= iir3_pkg::REG_A3; r++) begin
        idx = r[iir3_pkg::REG_IDX_W-1:0];
        write_reg(idx, pick_coef(kind));
      end
    end
    setting_count++;
  endtask

  function automatic logic [iir3_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      7:          return 32'h7FFF_FFFF;
      8:          return 32'h8000_0000;
      default:    return int'($urandom_range(0, 3)) - 1;
    endcase
  endfunction

  function automatic logic [iir3_pkg::CH_W-1:0] pick_channel();
    int unsigned ch;
    if ($urandom_range(0, 19) == 0) begin
      ch = $urandom_range(CHANNELS, 7);
    end else begin
      ch = $urandom_range(0, CHANNELS - 1);
    end
    return ch[iir3_pkg::CH_W-1:0];
  endfunction

  initial begin
    coef_set_e kinds [PHASES];
    kinds = '{COEFS_LOWPASS, COEFS_SMALL, COEFS_FULL, COEFS_EDGE, COEFS_SMALL, COEFS_LOWPASS};
    for (int i = 0; i < iir3_pkg::NUM_REGS; i++) coef_q[i] = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int t = 0; t < iir3_pkg::TAPS; t++) begin
        x_hist[c][t] = '0;
        y_hist[c][t] = '0;
      end
    end
    send_idle_pct = 34;
    recv_idle_pct = 80;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // all coefficients still zero after reset
    send(3'd0, 32'h7FFF_FFFF);
    send(3'd5, 32'h8000_0000);
    drain();

    // b0 = 0.5: round-to-nearest ties go toward plus infinity
    write_reg(iir3_pkg::REG_B0, 32'h0800_0000);
    send(3'd0, 32'd1);
    send(3'd0, 32'hFFFF_FFFF);
    send(3'd1, 32'd3);
    send(3'd1, 32'hFFFF_FFFD);
    send(3'd2, 32'h7FFF_FFFF);
    send(3'd2, 32'h8000_0000);
    send(3'd6, 32'd5);
    send(3'd7, 32'hFFFF_FFFF);
    drain();

    // extreme coefficients: saturation in both directions
    write_reg(iir3_pkg::REG_B0, 32'h7FFF_FFFF);
    write_reg(iir3_pkg::REG_B1, 32'h8000_0000);
    write_reg(iir3_pkg::REG_B2, 32'h7FFF_FFFF);
    write_reg(iir3_pkg::REG_B3, 32'h8000_0000);
    write_reg(iir3_pkg::REG_A1, 32'h8000_0000);
    write_reg(iir3_pkg::REG_A2, 32'h7FFF_FFFF);
    write_reg(iir3_pkg::REG_A3, 32'h8000_0000);
    write_reg(REG_UNUSED, 32'h1234_5678);
    setting_count += 3;
    send(3'd3, 32'h7FFF_FFFF);
    send(3'd3, 32'h7FFF_FFFF);
    send(3'd3, 32'h8000_0000);
    send(3'd3, 32'd0);
    send(3'd4, 32'h8000_0000);
    send(3'd4, 32'hFFFF_FFFF);
    send(3'd5, 32'd1);
    send(3'd6, 32'h8000_0000);
    send(3'd7, 32'h7FFF_FFFF);
    send(3'd4, 32'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 34;
        recv_idle_pct = 80;
      end else if (p < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_coefs(kinds[p]);
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) send(pick_channel(), pick_sample());
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    mismatch_count += expected_filtered.size();
    $display("Covered %0d items under %0d coefficient settings, %0d results checked;",
             accepted_count, setting_count, checked_count);
    $display("%0d saturated outputs, %0d items on unused channels, one long output hold-off.",
             saturated_count, idle_channel_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
